>>> rtl/mcxd_pkg.sv
`timescale 1ns / 1ps
package mcxd_pkg;

  typedef logic [31:0][7:0] key_t;

  localparam int unsigned HELD_DEPTH = 256;

  localparam logic [15:0] VID_CLEAR_END = 16'h0040;
  localparam logic [15:0] VID_HOLD_END  = 16'h0140;
  localparam logic [15:0] VID_MIN_LEN   = 16'h0240;
  localparam logic [15:0] AUD_START     = 16'h0140;
  localparam logic [15:0] HELD_SHIFT    = 16'h0100;
  localparam logic [15:0] POS_MAX       = 16'hffff;
  localparam logic [7:0]  HELD_BASE     = 8'h40;

  localparam logic KIND_VIDEO = 1'b0;
  localparam logic KIND_AUDIO = 1'b1;

  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] pos;
    logic [15:0] len;
    logic        kind;
    logic        start;
  } item_t;

  typedef struct packed {
    logic [15:0] offset;
    logic [7:0]  value;
    logic        last;
  } result_t;

  function automatic key_t derive_key(input logic [63:0] kn);
    key_t k;
    k[8'h00] = kn[7:0];
    k[8'h01] = kn[15:8];
    k[8'h02] = kn[23:16];
    k[8'h03] = kn[31:24] - 8'h34;
    k[8'h04] = kn[39:32] + 8'hf9;
    k[8'h05] = kn[47:40] ^ 8'h13;
    k[8'h06] = kn[55:48] + 8'h61;
    k[8'h07] = k[8'h00] ^ 8'hff;
    k[8'h08] = k[8'h01] + k[8'h02];
    k[8'h09] = k[8'h01] - k[8'h07];
    k[8'h0a] = k[8'h02] ^ 8'hff;
    k[8'h0b] = k[8'h01] ^ 8'hff;
    k[8'h0c] = k[8'h0b] + k[8'h09];
    k[8'h0d] = k[8'h08] - k[8'h03];
    k[8'h0e] = k[8'h0d] ^ 8'hff;
    k[8'h0f] = k[8'h0a] - k[8'h0b];
    k[8'h10] = k[8'h08] - k[8'h0f];
    k[8'h11] = k[8'h10] ^ k[8'h07];
    k[8'h12] = k[8'h0f] ^ 8'hff;
    k[8'h13] = k[8'h03] ^ 8'h10;
    k[8'h14] = k[8'h04] - 8'h32;
    k[8'h15] = k[8'h05] + 8'hed;
    k[8'h16] = k[8'h06] ^ 8'hf3;
    k[8'h17] = k[8'h13] - k[8'h0f];
    k[8'h18] = k[8'h15] + k[8'h07];
    k[8'h19] = 8'h21 - k[8'h13];
    k[8'h1a] = k[8'h14] ^ k[8'h17];
    k[8'h1b] = k[8'h16] + k[8'h16];
    k[8'h1c] = k[8'h17] + 8'h44;
    k[8'h1d] = k[8'h03] + k[8'h04];
    k[8'h1e] = k[8'h05] - k[8'h16];
    k[8'h1f] = k[8'h1d] ^ k[8'h13];
    return k;
  endfunction

  function automatic logic [7:0] audio_key(input key_t k, input logic [4:0] i);
    logic [7:0] a;
    a = ~k[i];
    if (i[0]) begin
      unique case (i[2:1])
        2'd0:    a = 8'h55;
        2'd1:    a = 8'h52;
        2'd2:    a = 8'h55;
        default: a = 8'h43;
      endcase
    end
    return a;
  endfunction

endpackage

>>> rtl/mcxd_held_ram.sv
`timescale 1ns / 1ps
module mcxd_held_ram
  import mcxd_pkg::*;
(
  input  logic       clk,
  input  logic       we,
  input  logic [7:0] waddr,
  input  logic [7:0] wdata,
  input  logic       re,
  input  logic [7:0] raddr,
  output logic [7:0] rdata
);

  logic [7:0] mem [HELD_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/mcxd_front.sv
`timescale 1ns / 1ps
module mcxd_front
  import mcxd_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        take,
  output logic        item_vld,
  output item_t       item,
  output logic        rd_en,
  output logic [7:0]  rd_addr
);

  logic [15:0] position;
  logic [15:0] length_held;
  logic        packet_kind;
  logic        start_in;
  logic [15:0] pos_in;
  logic [15:0] len_in;
  logic [15:0] len_clamped;
  logic        kind_in;

  assign s_axis_tready = !item_vld || take;
  assign rd_en         = s_axis_tvalid && s_axis_tready;
  assign start_in      = s_axis_tuser[1];

  always_comb begin
    len_clamped = s_axis_tdata[23:8];
    if (32'(s_axis_tdata[23:8]) > 32'(MAX_PACKET_BYTES)) begin
      len_clamped = 16'(MAX_PACKET_BYTES);
    end
    pos_in  = start_in ? '0 : position;
    len_in  = start_in ? len_clamped : length_held;
    kind_in = start_in ? s_axis_tuser[0] : packet_kind;
    rd_addr = pos_in[7:0] - HELD_BASE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld    <= 1'b0;
      position    <= '0;
      length_held <= '0;
      packet_kind <= KIND_VIDEO;
    end else begin
      if (rd_en) begin
        item_vld    <= 1'b1;
        length_held <= len_in;
        packet_kind <= kind_in;
        if (pos_in != POS_MAX) begin
          position <= pos_in + 16'd1;
        end else begin
          position <= pos_in;
        end
      end else if (take) begin
        item_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      item.data  <= s_axis_tdata[7:0];
      item.pos   <= pos_in;
      item.len   <= len_in;
      item.kind  <= kind_in;
      item.start <= start_in;
    end
  end

endmodule

>>> rtl/mcxd_core.sv
`timescale 1ns / 1ps
module mcxd_core
  import mcxd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        item_vld,
  input  item_t       item,
  input  logic [7:0]  held_rd,
  input  logic        room,
  output logic        take,
  output logic        held_we,
  output logic [7:0]  held_waddr,
  output logic [7:0]  held_wdata,
  output logic [1:0]  res_cnt,
  output result_t     res0,
  output result_t     res1
);

  key_t       key;
  logic [7:0] upper_key [32];
  logic [7:0] lower_key [32];

  logic [4:0] idx;
  logic [7:0] up_rd;
  logic [7:0] lo_rd;
  logic [7:0] plain;
  logic [7:0] lo_new;
  logic [7:0] up_new;
  logic       up_we;
  logic       lo_we;

  assign take       = item_vld && room;
  assign idx        = item.pos[4:0];
  assign up_rd      = item.start ? ~key[idx] : upper_key[idx];
  assign lo_rd      = item.start ? key[idx] : lower_key[idx];
  assign plain      = item.data ^ up_rd;
  assign lo_new     = lo_rd ^ plain;
  assign up_new     = plain ^ ~key[idx];
  assign held_waddr = item.pos[7:0] - HELD_BASE;
  assign held_wdata = item.data;

  always_comb begin
    res_cnt = 2'd0;
    held_we = 1'b0;
    up_we   = 1'b0;
    lo_we   = 1'b0;
    res0    = '{offset: item.pos, value: item.data, last: 1'b1};
    res1    = '{offset: item.pos, value: plain, last: 1'b1};
    priority if (item.pos >= item.len) begin
      res_cnt = 2'd1;
    end else if (item.kind == KIND_AUDIO) begin
      res_cnt = 2'd1;
      if (item.pos >= AUD_START) begin
        res0.value = item.data ^ audio_key(key, idx);
      end
    end else if (item.len < VID_MIN_LEN || item.pos < VID_CLEAR_END) begin
      res_cnt = 2'd1;
    end else if (item.pos < VID_HOLD_END) begin
      held_we = take;
    end else begin
      up_we = take;
      if (item.pos < VID_MIN_LEN) begin
        lo_we   = take;
        res_cnt = 2'd2;
        res0    = '{offset: item.pos - HELD_SHIFT, value: held_rd ^ lo_new, last: 1'b0};
      end else begin
        res_cnt    = 2'd1;
        res0.value = plain;
      end
    end
    if (!take) begin
      res_cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= derive_key(64'd0);
    end else if (cfg_we) begin
      key <= derive_key(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) begin
        upper_key[i] <= ~key[i];
        lower_key[i] <= key[i];
      end
    end else if (take) begin
      if (item.start) begin
        for (int i = 0; i < 32; i++) begin
          upper_key[i] <= ~key[i];
          lower_key[i] <= key[i];
        end
      end
      if (up_we) begin
        upper_key[idx] <= up_new;
      end
      if (lo_we) begin
        lower_key[idx] <= lo_new;
      end
    end
  end

endmodule

>>> rtl/mcxd_out_fifo.sv
`timescale 1ns / 1ps
module mcxd_out_fifo
  import mcxd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  push_cnt,
  input  result_t     res0,
  input  result_t     res1,
  output logic        room,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  result_t    mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign room          = count <= 3'd2;
  assign m_axis_tvalid = count != 3'd0;
  assign m_axis_tdata  = {mem[rd_ptr].offset, mem[rd_ptr].value};
  assign m_axis_tlast  = mem[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt;
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count + 3'(push_cnt) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= res0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr + 2'd1] <= res1;
    end
  end

endmodule

>>> rtl/media_chunk_xor_decryptor_unit.sv
`timescale 1ns / 1ps
// path: an accepted byte is registered in the front stage, then in the result queue
// throughput: one byte per cycle while each byte yields one result and the queue
// has room; video bytes 0x140..0x23f of packets >= 0x240 long yield two results each
// reset: position, length, kind and result queue clear; rolling keys load from key 0
module media_chunk_xor_decryptor_unit
  import mcxd_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // data_byte, packet_length
  input  logic [1:0]  s_axis_tuser,  // mode, packet_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // out_byte, byte_offset
  output logic        m_axis_tlast
);

  item_t      item;
  logic       item_vld;
  logic       take;
  logic       rd_en;
  logic [7:0] rd_addr;
  logic [7:0] held_rd;
  logic       held_we;
  logic [7:0] held_waddr;
  logic [7:0] held_wdata;
  logic [1:0] res_cnt;
  result_t    res0;
  result_t    res1;
  logic       room;

  mcxd_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .take         (take),
    .item_vld     (item_vld),
    .item         (item),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr)
  );

  mcxd_held_ram u_held (
    .clk  (clk),
    .we   (held_we),
    .waddr(held_waddr),
    .wdata(held_wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(held_rd)
  );

  mcxd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item_vld  (item_vld),
    .item      (item),
    .held_rd   (held_rd),
    .room      (room),
    .take      (take),
    .held_we   (held_we),
    .held_waddr(held_waddr),
    .held_wdata(held_wdata),
    .res_cnt   (res_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  mcxd_out_fifo u_out (
    .clk          (clk),
    .rst          (rst),
    .push_cnt     (res_cnt),
    .res0         (res0),
    .res1         (res1),
    .room         (room),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  a_pair_only_mid_video: assert property (@(posedge clk) disable iff (rst)
    res_cnt == 2'd2 |-> item.kind == KIND_VIDEO && item.pos >= VID_HOLD_END
                        && item.pos < VID_MIN_LEN)
    else $error("two results outside the release range");

  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |=> m_axis_tvalid)
    else $error("released byte without its partner result");

  a_start_at_zero: assert property (@(posedge clk) disable iff (rst)
    take && item.start |-> item.pos == 16'd0)
    else $error("packet start not at offset zero");

  a_no_hold_write_on_result: assert property (@(posedge clk) disable iff (rst)
    held_we |-> res_cnt == 2'd0)
    else $error("held byte also produced a result");

endmodule

>>> sim/media_chunk_xor_decryptor_unit_tb.sv
`timescale 1ns / 1ps
module media_chunk_xor_decryptor_unit_tb;
  import mcxd_pkg::*;

  localparam int unsigned MAX_BYTES = 65536;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam logic [3:0][7:0] AUDIO_TAG = {8'h43, 8'h55, 8'h52, 8'h55};

  typedef struct packed {
    logic [7:0]  value;
    logic [15:0] offset;
    logic        last;
  } plain_rec_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [63:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;  // data_byte, packet_length
  logic [1:0]  s_axis_tuser;  // mode, packet_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [23:0] m_axis_tdata;  // out_byte, byte_offset
  logic        m_axis_tlast;

  media_chunk_xor_decryptor_unit #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // decryptor state mirror
  logic [63:0] key_number_q;
  int unsigned byte_pos;
  logic        packet_kind;
  int unsigned held_len;
  logic [7:0]  upper_roll [32];
  logic [7:0]  lower_roll [32];
  logic [7:0]  held_store [256];

  plain_rec_t  pending_plain [$];
  plain_rec_t  head_rec;
  int unsigned bad_count;
  int unsigned cycle_count;
  int unsigned sent_count;
  int unsigned stall_left;
  logic        idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** media_chunk_xor_decryptor_unit: FAILED **");
      $finish;
    end
  end

  function automatic key_t expand_key_number(input logic [63:0] kn);
    key_t k;
    k[0]  = kn[7:0];
    k[1]  = kn[15:8];
    k[2]  = kn[23:16];
    k[3]  = kn[31:24] - 8'h34;
    k[4]  = kn[39:32] + 8'hf9;
    k[5]  = kn[47:40] ^ 8'h13;
    k[6]  = kn[55:48] + 8'h61;
    k[7]  = ~k[0];
    k[8]  = k[1] + k[2];
    k[9]  = k[1] - k[7];
    k[10] = ~k[2];
    k[11] = ~k[1];
    k[12] = k[11] + k[9];
    k[13] = k[8] - k[3];
    k[14] = ~k[13];
    k[15] = k[10] - k[11];
    k[16] = k[8] - k[15];
    k[17] = k[16] ^ k[7];
    k[18] = ~k[15];
    k[19] = k[3] ^ 8'h10;
    k[20] = k[4] - 8'h32;
    k[21] = k[5] + 8'hed;
    k[22] = k[6] ^ 8'hf3;
    k[23] = k[19] - k[15];
    k[24] = k[21] + k[7];
    k[25] = 8'h21 - k[19];
    k[26] = k[20] ^ k[23];
    k[27] = k[22] + k[22];
    k[28] = k[23] + 8'h44;
    k[29] = k[3] + k[4];
    k[30] = k[5] - k[22];
    k[31] = k[29] ^ k[19];
    return k;
  endfunction

  function automatic void load_rolling_keys();
    key_t kb;
    kb = expand_key_number(key_number_q);
    for (int i = 0; i < 32; i++) begin
      lower_roll[i] = kb[i];
      upper_roll[i] = ~kb[i];
    end
  endfunction

  function automatic void expect_plain(input logic [7:0] v, input int unsigned off,
                                       input logic last);
    plain_rec_t r;
    r.value  = v;
    r.offset = off[15:0];
    r.last   = last;
    pending_plain.push_back(r);
  endfunction

  function automatic void decrypt_byte(input logic mode, input logic [7:0] data,
                                       input logic start, input logic [15:0] len);
    key_t        kb;
    logic [7:0]  b;
    logic [7:0]  plain;
    logic [4:0]  idx;
    int unsigned p;
    logic [7:0]  j;
    if (start) begin
      byte_pos = 0;
      packet_kind = mode;
      held_len = (len > MAX_BYTES) ? MAX_BYTES : len;
      load_rolling_keys();
    end
    kb = expand_key_number(key_number_q);
    p = byte_pos;
    b = data;
    idx = p[4:0];
    if (p >= held_len) begin
      expect_plain(b, p, 1'b1);
    end else if (packet_kind == KIND_AUDIO) begin
      if (p >= AUD_START) begin
        b = b ^ (idx[0] ? AUDIO_TAG[idx[2:1]] : ~kb[idx]);
      end
      expect_plain(b, p, 1'b1);
    end else if (held_len < VID_MIN_LEN || p < VID_CLEAR_END) begin
      expect_plain(b, p, 1'b1);
    end else if (p < VID_HOLD_END) begin
      j = 8'(p - VID_CLEAR_END);
      held_store[j] = b;
    end else begin
      plain = b ^ upper_roll[idx];
      upper_roll[idx] = plain ^ ~kb[idx];
      if (p < VID_MIN_LEN) begin
        j = 8'(p - VID_HOLD_END);
        lower_roll[idx] = lower_roll[idx] ^ plain;
        expect_plain(held_store[j] ^ lower_roll[idx], VID_CLEAR_END + 32'(j), 1'b0);
      end
      expect_plain(plain, p, 1'b1);
    end
    if (byte_pos < POS_MAX) byte_pos++;
  endfunction

  task automatic flag_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    bad_count++;
    if (bad_count <= 10) begin
      $display("mismatch %s: expected 0x%0h got 0x%0h (cycle %0d)", field, want, got,
               cycle_count);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_plain.size() == 0) begin
        flag_mismatch("transfer with nothing pending", 0, {m_axis_tlast, m_axis_tdata});
      end else begin
        head_rec = pending_plain.pop_front();
        if (m_axis_tdata[7:0] !== head_rec.value)
          flag_mismatch("out_byte", head_rec.value, m_axis_tdata[7:0]);
        if (m_axis_tdata[23:8] !== head_rec.offset)
          flag_mismatch("byte_offset", head_rec.offset, m_axis_tdata[23:8]);
        if (m_axis_tlast !== head_rec.last)
          flag_mismatch("run_last", head_rec.last, m_axis_tlast);
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if (rst || !idle_on) begin
      m_axis_tready = 1'b1;
    end else if (stall_left != 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      m_axis_tready = 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  function automatic logic [63:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0) return 64'h0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_byte(input logic mode, input logic [7:0] data, input logic start,
                           input logic [15:0] len);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {len, data};
    s_axis_tuser  = {start, mode};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    decrypt_byte(mode, data, start, len);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_packet(input logic kind, input logic [15:0] len,
                             input int unsigned count, input logic with_start);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == 0 && with_start)
        send_byte(kind, pick_byte(), 1'b1, len);
      else
        send_byte(1'($urandom), pick_byte(), 1'b0, 16'($urandom));
    end
  endtask

  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (pending_plain.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_key(input logic [63:0] value);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    key_number_q = value;
    cfg_we = 1'b0;
  endtask

  task automatic test_before_start();
    send_byte(KIND_AUDIO, 8'h00, 1'b0, 16'hffff);
    send_byte(KIND_VIDEO, 8'hff, 1'b0, 16'h0000);
    send_byte(KIND_AUDIO, 8'h5a, 1'b0, 16'h8000);
    settle();
  endtask

  // video packet cut off inside the held range, the next start follows at once
  task automatic test_early_restart();
    write_key('1);
    send_packet(KIND_VIDEO, 16'h0300, 16'h0042, 1'b1);
  endtask

  task automatic test_short_video();
    send_packet(KIND_VIDEO, 16'h023f, 6, 1'b1);
    send_packet(KIND_VIDEO, 16'h0000, 2, 1'b1);
    settle();
  endtask

  task automatic test_audio();
    write_key(pick_key());
    send_packet(KIND_AUDIO, 16'h0148, 16'h0144, 1'b1);
    settle();
    write_key(pick_key());
    send_packet(KIND_AUDIO, 16'h0148, 5, 1'b0);
    settle();
  endtask

  // key changes mid-packet, second half runs with no idling
  task automatic test_video();
    write_key(pick_key());
    send_packet(KIND_VIDEO, 16'h0241, 16'h0160, 1'b1);
    settle();
    write_key(pick_key());
    idle_on = 1'b0;
    send_packet(KIND_VIDEO, 16'h0241, 16'h00e3, 1'b0);
    settle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    idle_on = 1'b1;
    bad_count = 0;
    cycle_count = 0;
    sent_count = 0;
    stall_left = 0;
    key_number_q = '0;
    byte_pos = 0;
    packet_kind = KIND_VIDEO;
    held_len = 0;
    load_rolling_keys();
    for (int i = 0; i < 256; i++) held_store[i] = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_before_start();
    test_early_restart();
    test_short_video();
    test_audio();
    test_video();

    if (bad_count == 0 && pending_plain.size() == 0) begin
      $display("** media_chunk_xor_decryptor_unit: PASSED **");
    end else begin
      $display("** media_chunk_xor_decryptor_unit: FAILED **");
    end
    $finish;
  end

endmodule
